>>> hdl/pdl_pkg.sv
// Package for the pet door lock controller: payload structs, register
// indexes, direction and flap codes, and the configuration register set.
// No dependencies.
`timescale 1ns / 1ps

package pdl_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;
  localparam int unsigned CountWidth    = 16;
  localparam int unsigned TimeWidth     = 32;
  localparam int unsigned IrWidth       = 12;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_MOTION_DELAY   = 3'd0,
    REG_CLOSE_AFTER    = 3'd1,
    REG_POWER_DOWN     = 3'd2,
    REG_OPEN_THRESHOLD = 3'd3,
    REG_ALLOW_INWARD   = 3'd4,
    REG_ALLOW_OUTWARD  = 3'd5
  } pdl_reg_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_IN   = 2'd1,
    DIR_OUT  = 2'd2,
    DIR_BOTH = 2'd3
  } pdl_dir_e;

  typedef enum logic [1:0] {
    WAY_NONE = 2'd0,
    WAY_IN   = 2'd1,
    WAY_OUT  = 2'd2
  } pdl_way_e;

  typedef struct packed {
    logic                 motion_in;
    logic                 motion_out;
    logic [TimeWidth-1:0] now_seconds;
    logic [IrWidth-1:0]   ir_inside;
    logic [IrWidth-1:0]   ir_outside;
  } pdl_tick_t;

  typedef struct packed {
    logic       locked_inward;
    logic       locked_outward;
    logic       servos_powered;
    logic [1:0] heading;
    logic       session_ended;
    logic [1:0] opened_way;
  } pdl_result_t;

  typedef struct packed {
    logic [CfgIndexWidth-1:0] index;
    logic [CfgDataWidth-1:0]  data;
  } pdl_cfg_wr_t;

  typedef struct packed {
    logic [CountWidth-1:0] motion_delay;
    logic [TimeWidth-1:0]  close_after_seconds;
    logic [TimeWidth-1:0]  power_down_after_seconds;
    logic [IrWidth-1:0]    opening_threshold;
    logic                  allow_inward;
    logic                  allow_outward;
  } pdl_cfg_t;

  localparam logic [CountWidth-1:0] MotionDelayReset = 16'd50;
  localparam logic [TimeWidth-1:0]  CloseAfterReset  = 32'd10;
  localparam logic [TimeWidth-1:0]  PowerDownReset   = 32'd60;
  localparam logic [IrWidth-1:0]    ThresholdReset   = 12'd2000;

endpackage : pdl_pkg

>>> hdl/pdl_chan_if.sv
// Valid/ready channel carrying one word of a payload type given as parameter.
// Used for the tick, result and configuration channels; no dependencies.
`timescale 1ns / 1ps

interface pdl_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : pdl_chan_if

>>> hdl/pdl_cfg_regs.sv
// Configuration register file of the pet door lock controller.
// Depends on pdl_pkg.
`timescale 1ns / 1ps

module pdl_cfg_regs
  import pdl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  pdl_cfg_wr_t wr_i,
  output pdl_cfg_t    cfg_o
);

  pdl_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (pdl_reg_e'(wr_i.index))
        REG_MOTION_DELAY:   cfg_d.motion_delay             = wr_i.data[CountWidth-1:0];
        REG_CLOSE_AFTER:    cfg_d.close_after_seconds      = wr_i.data[TimeWidth-1:0];
        REG_POWER_DOWN:     cfg_d.power_down_after_seconds = wr_i.data[TimeWidth-1:0];
        REG_OPEN_THRESHOLD: cfg_d.opening_threshold        = wr_i.data[IrWidth-1:0];
        REG_ALLOW_INWARD:   cfg_d.allow_inward             = wr_i.data[0];
        REG_ALLOW_OUTWARD:  cfg_d.allow_outward            = wr_i.data[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motion_delay             <= MotionDelayReset;
      cfg_q.close_after_seconds      <= CloseAfterReset;
      cfg_q.power_down_after_seconds <= PowerDownReset;
      cfg_q.opening_threshold        <= ThresholdReset;
      cfg_q.allow_inward             <= 1'b0;
      cfg_q.allow_outward            <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule : pdl_cfg_regs

>>> hdl/pdl_core.sv
// Per-tick state update of the pet door lock controller: motion counters,
// time stamps, lock, servo and session state. Depends on pdl_pkg.
`timescale 1ns / 1ps

module pdl_core
  import pdl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  pdl_tick_t   tick_i,
  input  pdl_cfg_t    cfg_i,
  output pdl_result_t result_o
);

  logic [CountWidth-1:0] in_cnt_q, in_cnt_d, out_cnt_q, out_cnt_d;
  logic [TimeWidth-1:0]  last_act_q, last_act_d;
  logic [TimeWidth-1:0]  last_in_chg_q, last_in_chg_d;
  logic [TimeWidth-1:0]  last_out_chg_q, last_out_chg_d;
  logic                  in_locked_q, in_locked_d, out_locked_q, out_locked_d;
  logic                  servo_q, servo_d, sess_q, sess_d, was_q, was_d;
  logic [1:0]            swing_q, swing_d;

  always_comb begin
    logic [CountWidth-1:0] in_cnt, out_cnt;
    logic [TimeWidth-1:0]  last_act, last_in_chg, last_out_chg, lull;
    logic                  q_in, q_out, in_lk, out_lk, servo, sess, was, ended;
    logic [1:0]            swing, way;
    pdl_dir_e              dir;

    // Motion counting saturates one past the delay, or at the counter top.
    last_act = (tick_i.motion_in || tick_i.motion_out) ? tick_i.now_seconds : last_act_q;
    in_cnt   = in_cnt_q;
    out_cnt  = out_cnt_q;
    if (tick_i.motion_in && in_cnt_q <= cfg_i.motion_delay && in_cnt_q != '1) begin
      in_cnt = in_cnt_q + 1'b1;
    end
    if (tick_i.motion_out && out_cnt_q <= cfg_i.motion_delay && out_cnt_q != '1) begin
      out_cnt = out_cnt_q + 1'b1;
    end

    // Inside motion means the pet heads out, outside motion means in.
    q_in  = tick_i.motion_in && (in_cnt > cfg_i.motion_delay);
    q_out = tick_i.motion_out && (out_cnt > cfg_i.motion_delay);
    if (q_in && q_out) begin
      dir = DIR_BOTH;
    end else if (q_in) begin
      dir = DIR_OUT;
    end else if (q_out) begin
      dir = DIR_IN;
    end else begin
      dir = DIR_NONE;
    end

    in_lk        = in_locked_q;
    out_lk       = out_locked_q;
    servo        = servo_q;
    sess         = sess_q;
    swing        = swing_q;
    last_in_chg  = last_in_chg_q;
    last_out_chg = last_out_chg_q;
    was          = (dir != DIR_NONE) ? sess_q : was_q;

    // Relock each side once its close timeout has run out.
    if ((tick_i.now_seconds - last_in_chg_q) > cfg_i.close_after_seconds && !in_lk) begin
      in_lk = 1'b1;
      servo = 1'b1;
    end
    if ((tick_i.now_seconds - last_out_chg_q) > cfg_i.close_after_seconds && !out_lk) begin
      out_lk = 1'b1;
      servo  = 1'b1;
    end

    lull = tick_i.now_seconds - last_act;
    if (lull > cfg_i.close_after_seconds) begin
      in_cnt  = '0;
      out_cnt = '0;
      sess    = 1'b0;
    end
    if (lull > cfg_i.power_down_after_seconds && servo) begin
      in_lk  = 1'b1;
      out_lk = 1'b1;
      servo  = 1'b0;
    end

    ended = 1'b0;
    way   = WAY_NONE;
    if (was && !sess) begin
      was   = 1'b0;
      ended = 1'b1;
      way   = swing;
      swing = WAY_NONE;
    end

    if (dir != DIR_NONE) begin
      sess = 1'b1;
      if (dir == DIR_IN && cfg_i.allow_inward) begin
        last_in_chg = tick_i.now_seconds;
        if (in_lk) begin
          in_lk = 1'b0;
          servo = 1'b1;
        end
      end
      if (dir == DIR_OUT && cfg_i.allow_outward) begin
        last_out_chg = tick_i.now_seconds;
        if (out_lk) begin
          out_lk = 1'b0;
          servo  = 1'b1;
        end
      end
      if (tick_i.ir_inside > cfg_i.opening_threshold) begin
        swing = WAY_IN;
      end
      if (tick_i.ir_outside > cfg_i.opening_threshold) begin
        swing = WAY_OUT;
      end
    end

    result_o.locked_inward  = in_lk;
    result_o.locked_outward = out_lk;
    result_o.servos_powered = servo;
    result_o.heading        = dir;
    result_o.session_ended  = ended;
    result_o.opened_way     = way;

    in_cnt_d       = step_i ? in_cnt       : in_cnt_q;
    out_cnt_d      = step_i ? out_cnt      : out_cnt_q;
    last_act_d     = step_i ? last_act     : last_act_q;
    last_in_chg_d  = step_i ? last_in_chg  : last_in_chg_q;
    last_out_chg_d = step_i ? last_out_chg : last_out_chg_q;
    in_locked_d    = step_i ? in_lk        : in_locked_q;
    out_locked_d   = step_i ? out_lk       : out_locked_q;
    servo_d        = step_i ? servo        : servo_q;
    sess_d         = step_i ? sess         : sess_q;
    was_d          = step_i ? was          : was_q;
    swing_d        = step_i ? swing        : swing_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q       <= '0;
      out_cnt_q      <= '0;
      last_act_q     <= '0;
      last_in_chg_q  <= '0;
      last_out_chg_q <= '0;
      in_locked_q    <= 1'b1;
      out_locked_q   <= 1'b1;
      servo_q        <= 1'b1;
      sess_q         <= 1'b0;
      was_q          <= 1'b0;
      swing_q        <= WAY_NONE;
    end else begin
      in_cnt_q       <= in_cnt_d;
      out_cnt_q      <= out_cnt_d;
      last_act_q     <= last_act_d;
      last_in_chg_q  <= last_in_chg_d;
      last_out_chg_q <= last_out_chg_d;
      in_locked_q    <= in_locked_d;
      out_locked_q   <= out_locked_d;
      servo_q        <= servo_d;
      sess_q         <= sess_d;
      was_q          <= was_d;
      swing_q        <= swing_d;
    end
  end

endmodule : pdl_core

>>> hdl/pet_door_lock_controller.sv
// Top level of the pet door lock controller: tick input register, state
// update core, result register and configuration registers.
// Depends on pdl_pkg, pdl_chan_if, pdl_cfg_regs and pdl_core.
`timescale 1ns / 1ps

// The controller takes tick words on tick_i and returns exactly one result
// word per tick on result_o, in order. A tick passes an input register, is
// evaluated combinationally by the state update core, and lands in the
// result register; a new tick is accepted every cycle while result_o is not
// stalled. The result register holds a word while result_o is stalled and
// the input register keeps taking ticks until both are full.
// Each result gives the lock state of both sides, servo power, the qualified
// motion direction of that tick, and at the end of an active session which
// way the flap swung. Configuration words on cfg_i are always accepted and
// take effect once registered; write them only while no tick is in flight. Register
// indexes follow pdl_reg_e, and writes to other indexes are ignored.

module pet_door_lock_controller
  import pdl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pdl_chan_if.sink   tick_i,
  pdl_chan_if.source result_o,
  pdl_chan_if.sink   cfg_i
);

  pdl_tick_t   tick_q;
  logic        tick_vld_q, tick_vld_d;
  pdl_result_t res_q, res_next;
  logic        res_vld_q, res_vld_d;
  logic        step;
  logic        tick_take;
  pdl_cfg_t    cfg;

  // A tick is evaluated when the result register is empty or is being drained.
  assign step      = tick_vld_q && (!res_vld_q || result_o.ready);
  assign tick_take = tick_i.valid && tick_i.ready;

  assign tick_i.ready = !tick_vld_q || step;
  assign cfg_i.ready  = 1'b1;

  pdl_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_i.valid),
    .wr_i    (cfg_i.data),
    .cfg_o   (cfg)
  );

  pdl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .tick_i   (tick_q),
    .cfg_i    (cfg),
    .result_o (res_next)
  );

  always_comb begin
    tick_vld_d = tick_vld_q;
    if (tick_take) begin
      tick_vld_d = 1'b1;
    end else if (step) begin
      tick_vld_d = 1'b0;
    end

    res_vld_d = res_vld_q;
    if (step) begin
      res_vld_d = 1'b1;
    end else if (result_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      tick_vld_q <= tick_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_take) begin
      tick_q <= tick_i.data;
    end
    if (step) begin
      res_q <= res_next;
    end
  end

  assign result_o.valid = res_vld_q;
  assign result_o.data  = res_q;

endmodule : pet_door_lock_controller
